>>> rtl/ihcv_pkg.sv
// shared types, constants and the crc-32/mpeg-2 word update for the image header crc verifier
// no dependencies
`default_nettype none

package ihcv_pkg;

  // header length in words and width of the image size field
  localparam int HEADER_WORDS = 10;
  localparam int SIZE_BITS    = 24;
  localparam int IDX_W        = SIZE_BITS - 1;
  localparam int LIMIT_W      = 24;
  localparam int ADDR_W       = 3;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // largest size value that fits the size field
  localparam logic [31:0] SIZE_MASK = 32'((64'd1 << SIZE_BITS) - 64'd1);

  // header word positions with special meaning
  localparam logic [IDX_W-1:0] IDX_STORED_CRC = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_SIZE       = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_HDR_WORDS  = IDX_W'(HEADER_WORDS);
  localparam logic [SIZE_BITS-1:0] HDR_BYTES  = SIZE_BITS'(4 * HEADER_WORDS);

  // register selects, decoded from paddr bit 2
  localparam logic REG_MAGIC = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(114688);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_BAD = 2'd1,
    ST_HDR_BAD = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0]        magic;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] crc;
  } result_t;

  // one 32-bit word into a non-reflected crc-32, msb first
  function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] word);
    logic [31:0] c;
    c = crc ^ word;
    for (int b = 0; b < 32; b++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ihcv_apb_regs.sv
// apb configuration registers: expected magic and size limit
// depends on ihcv_pkg
`default_nettype none

module ihcv_apb_regs import ihcv_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [31:0]        magic_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
      limit_q <= LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MAGIC: magic_q <= pwdata;
        REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
        default:   magic_q <= magic_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAGIC: prdata = magic_q;
      REG_LIMIT: prdata = 32'(limit_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.magic = magic_q;
  assign cfg_o.limit = limit_q;

endmodule

`default_nettype wire

>>> rtl/ihcv_check.sv
// check state and per-word update: header capture, crc update, end-of-image decision
// depends on ihcv_pkg
`default_nettype none

module ihcv_check import ihcv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [31:0] word_i,
  input  wire logic        first_i,
  input  wire cfg_t        cfg_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  logic [31:0]          crc_q, crc_d;
  logic [31:0]          stored_q, stored_d;
  logic [SIZE_BITS-1:0] bytes_q, bytes_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 magic_bad_q, magic_bad_d;
  logic                 active_q, active_d;

  // state after a possible restart
  logic [31:0]          crc_b, stored_b;
  logic [SIZE_BITS-1:0] bytes_b;
  logic [IDX_W-1:0]     idx_b;
  logic                 magic_bad_b, active_b;

  logic [31:0]          feed;
  logic [SIZE_BITS-1:0] size_clamp;
  logic [SIZE_BITS-1:0] body_words;
  logic [SIZE_BITS-1:0] body_done;
  logic                 hdr_bad;

  always_comb begin
    if (first_i) begin
      crc_b       = ALL_ONES;
      stored_b    = '0;
      bytes_b     = '0;
      idx_b       = '0;
      magic_bad_b = (word_i != cfg_i.magic);
      active_b    = 1'b1;
    end else begin
      crc_b       = crc_q;
      stored_b    = stored_q;
      bytes_b     = bytes_q;
      idx_b       = idx_q;
      magic_bad_b = magic_bad_q;
      active_b    = active_q;
    end
  end

  assign size_clamp = (word_i > SIZE_MASK) ? SIZE_MASK[SIZE_BITS-1:0]
                                           : word_i[SIZE_BITS-1:0];

  always_comb begin
    crc_d       = crc_q;
    stored_d    = stored_q;
    bytes_d     = bytes_q;
    idx_d       = idx_q;
    magic_bad_d = magic_bad_q;
    active_d    = active_q;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_OK, crc: 32'd0};
    feed        = word_i;
    body_words  = '0;
    body_done   = '0;
    hdr_bad     = 1'b0;

    if (step_i) begin
      crc_d       = crc_b;
      stored_d    = stored_b;
      bytes_d     = bytes_b;
      idx_d       = idx_b;
      magic_bad_d = magic_bad_b;
      active_d    = active_b;

      if (active_b) begin
        if (idx_b < IDX_HDR_WORDS) begin
          // stored crc and size words enter the crc as all ones
          if (idx_b == IDX_STORED_CRC) begin
            stored_d = word_i;
            feed     = ALL_ONES;
          end else if (idx_b == IDX_SIZE) begin
            bytes_d = size_clamp;
            feed    = ALL_ONES;
          end
        end
        crc_d = crc32_word(crc_b, feed);
        idx_d = idx_b + IDX_W'(1);

        body_words = (bytes_d - HDR_BYTES) >> 2;
        body_done  = SIZE_BITS'(idx_d - IDX_HDR_WORDS);
        hdr_bad    = magic_bad_d || (32'(bytes_d) >= 32'(cfg_i.limit)) ||
                     (bytes_d < HDR_BYTES);

        if (idx_b < IDX_HDR_WORDS) begin
          if (idx_d == IDX_HDR_WORDS) begin
            if (hdr_bad) begin
              res_valid_o = 1'b1;
              res_o       = '{status: ST_HDR_BAD, crc: 32'd0};
              active_d    = 1'b0;
            end else if (body_words == '0) begin
              res_valid_o = 1'b1;
              res_o       = '{status: (crc_d == stored_d) ? ST_OK : ST_CRC_BAD, crc: crc_d};
              active_d    = 1'b0;
            end
          end
        end else if (body_done >= body_words) begin
          res_valid_o = 1'b1;
          res_o       = '{status: (crc_d == stored_d) ? ST_OK : ST_CRC_BAD, crc: crc_d};
          active_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= ALL_ONES;
      stored_q    <= '0;
      bytes_q     <= '0;
      idx_q       <= '0;
      magic_bad_q <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      stored_q    <= stored_d;
      bytes_q     <= bytes_d;
      idx_q       <= idx_d;
      magic_bad_q <= magic_bad_d;
      active_q    <= active_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/image_header_crc_verifier.sv
// top level of the image header crc verifier: input register, check core, result register
// depends on ihcv_pkg, ihcv_apb_regs, ihcv_check
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------
//   in      | sink      | in_valid_i / in_ready_o   | image_word_i, first_word_i
//   out     | source    | out_valid_o / out_ready_i | status_o, computed_crc_o
//   apb     | slave     | psel, penable, pwrite     | paddr, pwdata, prdata
//
// one beat per cycle while the result register is not stalled; an input beat passes the
// input register, then the 32-bit parallel crc update into the result register
// at most one result beat per input beat, after the last header word or last body word
// a stalled result register holds its beat while the input register still takes one more
// async active-low reset leaves the check idle with the crc preset to all ones
`default_nettype none

module image_header_crc_verifier import ihcv_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input beats
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [31:0]       image_word_i,
  input  wire logic              first_word_i,
  // result beats
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [1:0]        status_o,
  output logic      [31:0]       computed_crc_o,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t        cfg;
  logic        in_vld_q;
  logic [31:0] word_q;
  logic        first_q;
  logic        out_vld_q;
  result_t     out_q;
  logic        advance;
  logic        res_valid;
  result_t     res;

  ihcv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the held beat moves on when the result register is empty or being drained
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q  <= image_word_i;
      first_q <= first_word_i;
    end
  end

  // header capture, crc update and the end-of-image decision
  ihcv_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .word_i      (word_q),
    .first_i     (first_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register, loaded only by a beat that yields a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_valid;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_q.status;
  assign computed_crc_o = out_q.crc;

endmodule

`default_nettype wire
